### hw/rtl/rotated_tile_write_addresser_core_defines.svh
// Assertion macros used by the rotated tile write addresser queue.
// Depends on nothing; files that assert include it by name.
`ifndef ROTATED_TILE_WRITE_ADDRESSER_CORE_DEFINES_SVH
`define ROTATED_TILE_WRITE_ADDRESSER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define RTWA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define RTWA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/rtwa_pkg.sv
// Package for the rotated tile write addresser: types and fixed constants.
// Used by the front, queue, back and top-level modules.
package rtwa_pkg;

  // Largest tile side that a header may ask for.
  localparam int MAX_DIM = 1024;

  // Depth of the queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_ROTATION   = 2'd0,
    CFG_NATIVE_W   = 2'd1,
    CFG_NATIVE_H   = 2'd2,
    CFG_SURF_PITCH = 2'd3
  } cfg_idx_t;

  // Display rotation codes.
  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  // One classified word passed from front to back.
  typedef struct packed {
    logic        wr;      // pixel write, else header result
    logic        status;  // header rejected
    logic        last;    // final pixel of the tile
    logic [11:0] row;     // absolute destination row
    logic [11:0] col;     // absolute destination column
    logic [15:0] pixel;
  } rtwa_item_t;

endpackage

### hw/rtl/rotated_tile_write_addresser_core.sv
// An accepted word is written to the queue, then to the output register.
// Throughput: one word per cycle, sustained while out_stall stays low; the
// four-word queue and the output register absorb short output stalls.
// The offset multiply and add sit in the back stage before the output register.
// Reset (synchronous, rst_n low): registers go to rotation 0 and 1024 for the
// sizes, the queue empties, the output goes invalid and no tile is open.
module rotated_tile_write_addresser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [9:0]  in_tile_x,
  input  logic [9:0]  in_tile_y,
  input  logic [10:0] in_tile_width,
  input  logic [10:0] in_tile_height,
  input  logic [15:0] in_pixel_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic        out_write_enable,
  output logic [20:0] out_byte_offset,
  output logic [15:0] out_pixel_out,
  output logic        out_last_pixel
);
  import rtwa_pkg::*;

  logic [1:0]  rotation_r;
  logic [10:0] native_w_r;
  logic [10:0] native_h_r;
  logic [10:0] surf_pitch_r;

  logic        in_accept;
  logic        push_valid;
  rtwa_item_t  push_data;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  rtwa_item_t  q_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotation_r   <= ROT_0;
      native_w_r   <= 11'd1024;
      native_h_r   <= 11'd1024;
      surf_pitch_r <= 11'd1024;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROTATION:   rotation_r   <= cfg_data[1:0];
        CFG_NATIVE_W:   native_w_r   <= cfg_data;
        CFG_NATIVE_H:   native_h_r   <= cfg_data;
        CFG_SURF_PITCH: surf_pitch_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input handshake: stall only when the queue is full.
  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  rtwa_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_accept      (in_accept),
    .in_cmd         (in_cmd),
    .in_tile_x      (in_tile_x),
    .in_tile_y      (in_tile_y),
    .in_tile_width  (in_tile_width),
    .in_tile_height (in_tile_height),
    .in_pixel_in    (in_pixel_in),
    .rotation       (rotation_r),
    .native_w       (native_w_r),
    .native_h       (native_h_r),
    .push_valid     (push_valid),
    .push_data      (push_data)
  );

  rtwa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_data   (q_data)
  );

  rtwa_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_data           (q_data),
    .q_pop            (q_pop),
    .surf_pitch       (surf_pitch_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_write_enable (out_write_enable),
    .out_byte_offset  (out_byte_offset),
    .out_pixel_out    (out_pixel_out),
    .out_last_pixel   (out_last_pixel)
  );

endmodule

### hw/rtl/rtwa_front.sv
// Front part: accepts input words, checks headers, tracks the open tile and
// maps each pixel to its rotated position. Depends on rtwa_pkg.
module rtwa_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_accept,
  input  logic                in_cmd,
  input  logic [9:0]          in_tile_x,
  input  logic [9:0]          in_tile_y,
  input  logic [10:0]         in_tile_width,
  input  logic [10:0]         in_tile_height,
  input  logic [15:0]         in_pixel_in,
  input  logic [1:0]          rotation,
  input  logic [10:0]         native_w,
  input  logic [10:0]         native_h,
  output logic                push_valid,
  output rtwa_pkg::rtwa_item_t push_data
);
  import rtwa_pkg::*;

  logic        open_r, open_nxt;
  rot_t        rot_r, rot_nxt;
  logic [10:0] ox_r, ox_nxt;
  logic [10:0] oy_r, oy_nxt;
  logic [10:0] hw_r, hw_nxt;
  logic [10:0] hh_r, hh_nxt;
  logic [10:0] col_r, col_nxt;
  logic [10:0] row_r, row_nxt;

  logic        is_hdr;
  logic        reject;
  logic [11:0] x_end;
  logic [11:0] y_end;
  logic [10:0] org_x;
  logic [10:0] org_y;
  logic [10:0] h_rev;
  logic [10:0] w_rev;
  logic [10:0] dx;
  logic [10:0] dy;
  logic        col_wrap;
  logic        row_wrap;

  assign is_hdr = !in_cmd;

  // Header check: empty or oversize tile, or a tile past the panel edge.
  assign x_end  = {2'b00, in_tile_x} + {1'b0, in_tile_width};
  assign y_end  = {2'b00, in_tile_y} + {1'b0, in_tile_height};
  assign reject = (in_tile_width == '0) || (in_tile_height == '0) ||
                  ({2'b00, in_tile_width} > 13'(MAX_DIM)) ||
                  ({2'b00, in_tile_height} > 13'(MAX_DIM)) ||
                  (x_end > {1'b0, native_w}) || (y_end > {1'b0, native_h});

  // Rotated origin of an accepted header.
  always_comb begin
    unique case (rot_t'(rotation))
      ROT_90: begin
        org_x = 11'(native_h - {1'b0, in_tile_y} - in_tile_height);
        org_y = {1'b0, in_tile_x};
      end
      ROT_180: begin
        org_x = 11'(native_w - {1'b0, in_tile_x} - in_tile_width);
        org_y = 11'(native_h - {1'b0, in_tile_y} - in_tile_height);
      end
      ROT_270: begin
        org_x = {1'b0, in_tile_y};
        org_y = 11'(native_w - {1'b0, in_tile_x} - in_tile_width);
      end
      default: begin
        org_x = {1'b0, in_tile_x};
        org_y = {1'b0, in_tile_y};
      end
    endcase
  end

  // Offset of the current source pixel inside the rotated tile.
  assign h_rev = 11'(hh_r - 11'd1 - row_r);
  assign w_rev = 11'(hw_r - 11'd1 - col_r);
  always_comb begin
    unique case (rot_r)
      ROT_90: begin
        dx = h_rev;
        dy = col_r;
      end
      ROT_180: begin
        dx = w_rev;
        dy = h_rev;
      end
      ROT_270: begin
        dx = row_r;
        dy = w_rev;
      end
      default: begin
        dx = col_r;
        dy = row_r;
      end
    endcase
  end

  // Row-major walk over the source tile.
  assign col_wrap = ({1'b0, col_r} + 12'd1) >= {1'b0, hw_r};
  assign row_wrap = ({1'b0, row_r} + 12'd1) >= {1'b0, hh_r};

  // Word handed to the queue.
  always_comb begin
    push_valid      = in_accept && (is_hdr || open_r);
    push_data.wr    = !is_hdr;
    push_data.status = is_hdr && reject;
    push_data.last  = !is_hdr && col_wrap && row_wrap;
    push_data.row   = {1'b0, oy_r} + {1'b0, dy};
    push_data.col   = {1'b0, ox_r} + {1'b0, dx};
    push_data.pixel = in_pixel_in;
  end

  // Tile state update.
  always_comb begin
    open_nxt = open_r;
    rot_nxt  = rot_r;
    ox_nxt   = ox_r;
    oy_nxt   = oy_r;
    hw_nxt   = hw_r;
    hh_nxt   = hh_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (in_accept && is_hdr) begin
      open_nxt = !reject;
      if (!reject) begin
        rot_nxt = rot_t'(rotation);
        ox_nxt  = org_x;
        oy_nxt  = org_y;
        hw_nxt  = in_tile_width;
        hh_nxt  = in_tile_height;
        col_nxt = '0;
        row_nxt = '0;
      end
    end else if (in_accept && open_r) begin
      if (col_wrap) begin
        col_nxt = '0;
        if (row_wrap) begin
          row_nxt  = '0;
          open_nxt = 1'b0;
        end else begin
          row_nxt = 11'(row_r + 11'd1);
        end
      end else begin
        col_nxt = 11'(col_r + 11'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      rot_r  <= ROT_0;
      ox_r   <= '0;
      oy_r   <= '0;
      hw_r   <= '0;
      hh_r   <= '0;
      col_r  <= '0;
      row_r  <= '0;
    end else begin
      open_r <= open_nxt;
      rot_r  <= rot_nxt;
      ox_r   <= ox_nxt;
      oy_r   <= oy_nxt;
      hw_r   <= hw_nxt;
      hh_r   <= hh_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
    end
  end

endmodule

### hw/rtl/rtwa_queue.sv
// Short queue between front and back of the rotated tile write addresser.
// Depends on rtwa_pkg and the assertion macro header.
`include "rotated_tile_write_addresser_core_defines.svh"
module rtwa_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  input  rtwa_pkg::rtwa_item_t push_data,
  output logic                 full,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output rtwa_pkg::rtwa_item_t pop_data
);
  import rtwa_pkg::*;

  rtwa_item_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                push;
  logic                pop;

  assign full      = (count_r == QCNT_W'(QDEPTH));
  assign pop_valid = (count_r != '0);
  assign push      = push_valid && !full;
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = mem_r[rd_ptr_r];

  // Pointer and fill bookkeeping; pointers wrap at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      count_nxt = QCNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = QCNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `RTWA_ASSERT_NOW(a_count_bound, 1'b1, count_r <= QCNT_W'(QDEPTH), "queue count past depth")
  `RTWA_ASSERT_NEXT(a_empty_fill, push && !pop && (count_r == '0), pop_data == $past(push_data), "word pushed into empty queue not at head")
  `RTWA_ASSERT_NEXT(a_pop_drain, pop && !push, count_r == $past(count_r) - 1'b1, "queue count did not drop on pop")

endmodule

### hw/rtl/rtwa_back.sv
// Back part: turns queued words into result words with the composite byte
// offset, held in an output register. Depends on rtwa_pkg.
module rtwa_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  rtwa_pkg::rtwa_item_t q_data,
  output logic                 q_pop,
  input  logic [10:0]          surf_pitch,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_status,
  output logic                 out_write_enable,
  output logic [20:0]          out_byte_offset,
  output logic [15:0]          out_pixel_out,
  output logic                 out_last_pixel
);
  import rtwa_pkg::*;

  logic        valid_r, valid_nxt;
  logic        status_r;
  logic        we_r;
  logic [20:0] offset_r;
  logic [15:0] pixel_r;
  logic        last_r;
  logic [19:0] lin;
  logic [20:0] offset_nxt;

  // Load a new word whenever the output register is free or being taken.
  assign q_pop = q_valid && (!valid_r || !out_stall);

  // Linear pixel index on the composite surface, kept to the bits that
  // survive doubling into a 21-bit byte offset.
  assign lin        = 20'({12'd0, q_data.row} * {13'd0, surf_pitch}) + {8'd0, q_data.col};
  assign offset_nxt = q_data.wr ? {lin, 1'b0} : '0;

  always_comb begin
    if (q_pop) begin
      valid_nxt = 1'b1;
    end else begin
      valid_nxt = valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Result fields; header results carry only the status.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      status_r <= q_data.status;
      we_r     <= q_data.wr;
      offset_r <= offset_nxt;
      pixel_r  <= q_data.wr ? q_data.pixel : '0;
      last_r   <= q_data.last;
    end
  end

  assign out_valid        = valid_r;
  assign out_status       = status_r;
  assign out_write_enable = we_r;
  assign out_byte_offset  = offset_r;
  assign out_pixel_out    = pixel_r;
  assign out_last_pixel   = last_r;

endmodule
